[rtl/core/iap_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iap_pkg;

    typedef enum logic [1:0] {
        CFG_MIN_PACKET_LENGTH = 2'd0,
        CFG_COMPANY_ID        = 2'd1,
        CFG_BEACON_PREFIX     = 2'd2,
        CFG_NEAR_DISTANCE_Q8  = 2'd3
    } t_cfg_index;

    localparam logic [4:0]  RST_MIN_PACKET_LENGTH = 5'd29;
    localparam logic [15:0] RST_COMPANY_ID        = 16'h004C;
    localparam logic [15:0] RST_BEACON_PREFIX     = 16'h0215;
    localparam logic [15:0] RST_NEAR_DISTANCE_Q8  = 16'd256;

    localparam logic [7:0] TYPE_MANUF    = 8'hFF;
    localparam logic [7:0] MIN_FIELD_LEN = 8'd25;

    // Byte positions inside a manufacturer field, counted from its length byte.
    localparam logic [8:0] REL_TYPE      = 9'd1;
    localparam logic [8:0] REL_COMPANY_L = 9'd2;
    localparam logic [8:0] REL_COMPANY_H = 9'd3;
    localparam logic [8:0] REL_PREFIX_H  = 9'd4;
    localparam logic [8:0] REL_PREFIX_L  = 9'd5;
    localparam logic [8:0] REL_MAJOR_H   = 9'd22;
    localparam logic [8:0] REL_MAJOR_L   = 9'd23;
    localparam logic [8:0] REL_MINOR_H   = 9'd24;
    localparam logic [8:0] REL_MINOR_L   = 9'd25;
    localparam logic [8:0] REL_TX_POWER  = 9'd26;

    localparam int unsigned DIST_ENTRIES = 49;
    localparam logic [15:0] DIST_SATURATED = 16'hFFFF;

    localparam logic [15:0] DIST_Q8 [DIST_ENTRIES] = '{
        16'd256,   16'd287,   16'd322,   16'd362,   16'd406,
        16'd455,   16'd511,   16'd573,   16'd643,   16'd722,
        16'd810,   16'd908,   16'd1019,  16'd1144,  16'd1283,
        16'd1440,  16'd1615,  16'd1812,  16'd2033,  16'd2282,
        16'd2560,  16'd2872,  16'd3223,  16'd3616,  16'd4057,
        16'd4552,  16'd5108,  16'd5731,  16'd6430,  16'd7215,
        16'd8095,  16'd9083,  16'd10192, 16'd11435, 16'd12830,
        16'd14396, 16'd16153, 16'd18123, 16'd20335, 16'd22816,
        16'd25600, 16'd28724, 16'd32228, 16'd36161, 16'd40573,
        16'd45524, 16'd51079, 16'd57311, 16'd64304
    };

    typedef struct packed {
        logic        found;
        logic [15:0] major;
        logic [15:0] minor;
        logic [7:0]  cal_power;
    } t_capture;

endpackage

`default_nettype wire

[rtl/core/iap_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface iap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] adv_byte;
    logic signed [7:0] rssi_dbm;
    logic       last_byte;

    modport source (output valid, output adv_byte, output rssi_dbm, output last_byte,
                    input ready);
    modport sink (input valid, input adv_byte, input rssi_dbm, input last_byte,
                  output ready);
endinterface

interface iap_out_if;
    logic        valid;
    logic        ready;
    logic        beacon_found;
    logic [15:0] major_id;
    logic [15:0] minor_id;
    logic signed [7:0] tx_power_dbm;
    logic signed [7:0] rssi_out;
    logic [7:0]  path_loss_db;
    logic [15:0] distance_q8;
    logic        is_near;

    modport source (output valid, output beacon_found, output major_id, output minor_id,
                    output tx_power_dbm, output rssi_out, output path_loss_db,
                    output distance_q8, output is_near, input ready);
    modport sink (input valid, input beacon_found, input major_id, input minor_id,
                  input tx_power_dbm, input rssi_out, input path_loss_db,
                  input distance_q8, input is_near, output ready);
endinterface

interface iap_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

[rtl/core/ibeacon_advert_parser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming iBeacon parser: one advertisement byte is taken per clock cycle, with no gaps
// needed between bytes or packets. The byte walker updates its field state in the cycle a
// byte is accepted, and on the last byte it hands a capture record to a second register
// stage that works out path loss, the table distance and the near flag, and the result item
// is then registered in the result register. The input is stalled only when both the capture
// stage and the result register hold items the sink has not taken.

module ibeacon_advert_parser_unit #(
    parameter int MAX_PACKET_BYTES  = 31,
    parameter int DISTANCE_TABLE_DB = 49
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    iap_in_if.sink    i_adv,
    iap_cfg_if.sink   i_cfg,
    iap_out_if.source o_res
);
    import iap_pkg::*;

    localparam logic [8:0] TABLE_DB = 9'(DISTANCE_TABLE_DB);
    localparam logic [8:0] TABLE_N  = 9'(DIST_ENTRIES);

    logic [4:0]  r_min_packet_length;
    logic [15:0] r_company_id;
    logic [15:0] r_beacon_prefix;
    logic [15:0] r_near_distance_q8;

    logic     in_take;
    logic     s1_ready;
    logic     s2_ready;
    t_capture capture;

    logic       r_s1_valid;
    t_capture   r_s1_cap;
    logic [7:0] r_s1_rssi;

    logic        r_out_valid;
    logic        r_out_found;
    logic [15:0] r_out_major;
    logic [15:0] r_out_minor;
    logic [7:0]  r_out_tx;
    logic [7:0]  r_out_rssi;
    logic [7:0]  r_out_loss;
    logic [15:0] r_out_dist;
    logic        r_out_near;

    logic [8:0]  loss_diff;
    logic [7:0]  n_loss;
    logic [15:0] n_dist;

    assign s2_ready    = !r_out_valid || o_res.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_adv.ready = s1_ready;
    assign in_take     = i_adv.valid && s1_ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_packet_length <= RST_MIN_PACKET_LENGTH;
            r_company_id        <= RST_COMPANY_ID;
            r_beacon_prefix     <= RST_BEACON_PREFIX;
            r_near_distance_q8  <= RST_NEAR_DISTANCE_Q8;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.reg_index))
                CFG_MIN_PACKET_LENGTH: r_min_packet_length <= i_cfg.wr_data[4:0];
                CFG_COMPANY_ID:        r_company_id        <= i_cfg.wr_data;
                CFG_BEACON_PREFIX:     r_beacon_prefix     <= i_cfg.wr_data;
                CFG_NEAR_DISTANCE_Q8:  r_near_distance_q8  <= i_cfg.wr_data;
                default:               r_near_distance_q8  <= r_near_distance_q8;
            endcase
        end
    end

    iap_field_walker #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_walker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_take              (in_take),
        .i_adv_byte          (i_adv.adv_byte),
        .i_last_byte         (i_adv.last_byte),
        .i_min_packet_length (r_min_packet_length),
        .i_company_id        (r_company_id),
        .i_beacon_prefix     (r_beacon_prefix),
        .o_capture           (capture)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= in_take && i_adv.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_cap  <= capture;
            r_s1_rssi <= i_adv.rssi_dbm;
        end
    end

    assign loss_diff = {r_s1_cap.cal_power[7], r_s1_cap.cal_power}
                     - {r_s1_rssi[7], r_s1_rssi};

    always_comb begin
        if ($signed(r_s1_rssi) >= $signed(r_s1_cap.cal_power)) begin
            n_loss = 8'd0;
        end else begin
            n_loss = loss_diff[7:0];
        end
        if (({1'b0, n_loss} < TABLE_DB) && ({1'b0, n_loss} < TABLE_N)) begin
            n_dist = DIST_Q8[n_loss[5:0]];
        end else begin
            n_dist = DIST_SATURATED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_out_found <= r_s1_cap.found;
            r_out_rssi  <= r_s1_rssi;
            if (r_s1_cap.found) begin
                r_out_major <= r_s1_cap.major;
                r_out_minor <= r_s1_cap.minor;
                r_out_tx    <= r_s1_cap.cal_power;
                r_out_loss  <= n_loss;
                r_out_dist  <= n_dist;
                r_out_near  <= (n_dist < r_near_distance_q8);
            end else begin
                r_out_major <= '0;
                r_out_minor <= '0;
                r_out_tx    <= '0;
                r_out_loss  <= '0;
                r_out_dist  <= '0;
                r_out_near  <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.beacon_found = r_out_found;
    assign o_res.major_id     = r_out_major;
    assign o_res.minor_id     = r_out_minor;
    assign o_res.tx_power_dbm = r_out_tx;
    assign o_res.rssi_out     = r_out_rssi;
    assign o_res.path_loss_db = r_out_loss;
    assign o_res.distance_q8  = r_out_dist;
    assign o_res.is_near      = r_out_near;

    a_near_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.is_near |-> o_res.beacon_found)
        else $error("Near flag raised without a beacon.");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.beacon_found |->
            (o_res.distance_q8 == 16'd0) && (o_res.path_loss_db == 8'd0)
            && (o_res.major_id == 16'd0))
        else $error("Result fields not cleared for a packet without a beacon.");

    a_zero_loss_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.beacon_found && (o_res.path_loss_db == 8'd0) |->
            (o_res.distance_q8 == DIST_Q8[0]))
        else $error("Zero path loss must map to the one meter distance.");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv.ready |-> r_s1_valid && r_out_valid && !o_res.ready)
        else $error("Input stalled while a pipeline stage is free.");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_ready |=> r_s1_valid && $stable(r_s1_cap))
        else $error("Capture stage item lost during a stall.");

endmodule

`default_nettype wire

[rtl/core/iap_field_walker.sv]
`timescale 1ns / 1ps
`default_nettype none

module iap_field_walker #(
    parameter int MAX_PACKET_BYTES = 31
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_take,
    input  wire  [7:0]        i_adv_byte,
    input  wire               i_last_byte,
    input  wire  [4:0]        i_min_packet_length,
    input  wire  [15:0]       i_company_id,
    input  wire  [15:0]       i_beacon_prefix,
    output iap_pkg::t_capture o_capture
);
    import iap_pkg::*;

    localparam int OFFW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [OFFW-1:0] MAX_OFF = OFFW'(MAX_PACKET_BYTES);

    logic [OFFW-1:0] r_offset, n_offset;
    logic [8:0]      r_next_start, n_next_start;
    logic [7:0]      r_field_len, n_field_len;
    logic            r_matching, n_matching;
    logic            r_found, n_found;
    logic [15:0]     r_major, n_major;
    logic [15:0]     r_minor, n_minor;
    logic [7:0]      r_cal_power, n_cal_power;

    logic [8:0] pos;
    logic [8:0] field_start;
    logic [8:0] rel;
    logic       byte_ok;
    logic       walk;

    assign pos         = {{(9 - OFFW){1'b0}}, r_offset};
    assign field_start = r_next_start - {1'b0, r_field_len} - 9'd1;
    assign rel         = pos - field_start;
    assign walk        = i_take && (r_offset < MAX_OFF);

    always_comb begin
        n_offset     = r_offset;
        n_next_start = r_next_start;
        n_field_len  = r_field_len;
        n_matching   = r_matching;
        n_found      = r_found;
        n_major      = r_major;
        n_minor      = r_minor;
        n_cal_power  = r_cal_power;
        byte_ok      = 1'b1;
        if (walk) begin
            if (r_matching) begin
                case (rel)
                    REL_TYPE:      byte_ok = (i_adv_byte == TYPE_MANUF);
                    REL_COMPANY_L: byte_ok = (i_adv_byte == i_company_id[7:0]);
                    REL_COMPANY_H: byte_ok = (i_adv_byte == i_company_id[15:8]);
                    REL_PREFIX_H:  byte_ok = (i_adv_byte == i_beacon_prefix[15:8]);
                    REL_PREFIX_L:  byte_ok = (i_adv_byte == i_beacon_prefix[7:0]);
                    REL_MAJOR_H:   n_major = {i_adv_byte, 8'd0};
                    REL_MAJOR_L:   n_major = {r_major[15:8], i_adv_byte};
                    REL_MINOR_H:   n_minor = {i_adv_byte, 8'd0};
                    REL_MINOR_L:   n_minor = {r_minor[15:8], i_adv_byte};
                    REL_TX_POWER: begin
                        n_cal_power = i_adv_byte;
                        n_found     = 1'b1;
                        byte_ok     = 1'b0;
                    end
                    default:       byte_ok = 1'b1;
                endcase
                if (!byte_ok) begin
                    n_matching = 1'b0;
                end
            end
            if (!n_found && !n_matching && (pos == r_next_start)) begin
                n_field_len  = i_adv_byte;
                n_next_start = pos + {1'b0, i_adv_byte} + 9'd1;
                n_matching   = (i_adv_byte >= MIN_FIELD_LEN);
            end
            n_offset = r_offset + OFFW'(1);
        end
    end

    always_comb begin
        o_capture.found     = n_found &&
                              ({{(9 - OFFW){1'b0}}, n_offset} >= {4'd0, i_min_packet_length});
        o_capture.major     = n_major;
        o_capture.minor     = n_minor;
        o_capture.cal_power = n_cal_power;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_next_start <= '0;
            r_field_len  <= '0;
            r_matching   <= 1'b0;
            r_found      <= 1'b0;
            r_major      <= '0;
            r_minor      <= '0;
            r_cal_power  <= '0;
        end else if (i_take && i_last_byte) begin
            r_offset     <= '0;
            r_next_start <= '0;
            r_field_len  <= '0;
            r_matching   <= 1'b0;
            r_found      <= 1'b0;
            r_major      <= '0;
            r_minor      <= '0;
            r_cal_power  <= '0;
        end else begin
            r_offset     <= n_offset;
            r_next_start <= n_next_start;
            r_field_len  <= n_field_len;
            r_matching   <= n_matching;
            r_found      <= n_found;
            r_major      <= n_major;
            r_minor      <= n_minor;
            r_cal_power  <= n_cal_power;
        end
    end

endmodule

`default_nettype wire
